>>> rtl/core/cqs_pkg.sv
`timescale 1ns / 1ps

package cqs_pkg;

  localparam int unsigned Depth = 8;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_RPT = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SCAN,
    ST_DONE
  } cqs_state_e;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/circular_queue_with_stats.sv
`timescale 1ns / 1ps

// Ring queue of Depth signed 32-bit entries with occupancy statistics.
// Input channel: in_valid_i / in_stall_o carry mode_i and value_i.
//   mode 0 enqueues value_i, mode 1 dequeues the oldest entry,
//   mode 2 reports count, sum, minimum and maximum of held entries,
//   mode 3 does nothing and reports the current count and flags.
// Output channel: out_valid_o / out_stall_i carry one result per item.
// in_stall_o is high from the cycle after an item is taken until its
// result has been loaded into the output register, so one item is in
// flight at a time. Path from acceptance to the output register:
//   enqueue, refused dequeue, empty report, mode 3: ST_DONE
//   dequeue: ST_DEQ (one registered read of the entry store), ST_DONE
//   report:  ST_SCAN, one stored entry summed per cycle
//            through the single read port of the entry store, ST_DONE.
// A new item can be taken in the cycle after the previous result is loaded,
// while that result may still wait in the output register.
// If out_stall_i holds a result, the next result waits in the sequencer
// and the input stays stalled until the output register is free.
// Reset empties the queue and clears out_valid_o; stored entries
// are not cleared and are never used while unoccupied.
module circular_queue_with_stats
  import cqs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] removed_value_o,
  output logic [3:0]         entry_count_o,
  output logic signed [34:0] entry_sum_o,
  output logic signed [31:0] entry_min_o,
  output logic signed [31:0] entry_max_o,
  output logic               is_full_o,
  output logic               is_empty_o
);

  logic signed [31:0] mem_q [Depth];
  logic signed [31:0] rdata_q;
  logic [PtrW-1:0]    rd_addr;
  logic               mem_we;

  cqs_state_e      state_q, state_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] scan_ptr_q, scan_ptr_d;
  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] left_q, left_d;
  logic            first_q, first_d;

  logic [1:0]         status_q, status_d;
  logic signed [31:0] removed_q, removed_d;
  logic signed [34:0] sum_q, sum_d;
  logic signed [31:0] min_q, min_d;
  logic signed [31:0] max_q, max_d;

  logic out_valid_q;
  logic out_load;
  logic occ_full;

  assign occ_full   = (occ_q == CntW'(Depth));
  assign in_stall_o = (state_q != ST_IDLE);
  assign rd_addr    = (state_q == ST_SCAN) ? scan_ptr_q : rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= value_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d    = state_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    scan_ptr_d = scan_ptr_q;
    occ_d      = occ_q;
    left_d     = left_q;
    first_d    = first_q;
    status_d   = status_q;
    removed_d  = removed_q;
    sum_d      = sum_q;
    min_d      = min_q;
    max_d      = max_q;
    mem_we     = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          status_d  = STAT_OK;
          removed_d = '0;
          sum_d     = '0;
          min_d     = '0;
          max_d     = '0;
          state_d   = ST_DONE;
          case (mode_i)
            MODE_ENQ: begin
              if (occ_full) begin
                status_d = STAT_FULL;
              end else begin
                mem_we   = 1'b1;
                wr_ptr_d = next_slot(wr_ptr_q);
                occ_d    = occ_q + CntW'(1);
              end
            end
            MODE_DEQ: begin
              if (occ_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                state_d = ST_DEQ;
              end
            end
            MODE_RPT: begin
              if (occ_q != '0) begin
                scan_ptr_d = next_slot(rd_ptr_q);
                left_d     = occ_q;
                first_d    = 1'b1;
                state_d    = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DEQ: begin
        removed_d = rdata_q;
        rd_ptr_d  = next_slot(rd_ptr_q);
        occ_d     = occ_q - CntW'(1);
        state_d   = ST_DONE;
      end
      ST_SCAN: begin
        sum_d = sum_q + {{3{rdata_q[31]}}, rdata_q};
        if (first_q || (rdata_q < min_q)) begin
          min_d = rdata_q;
        end
        if (first_q || (rdata_q > max_q)) begin
          max_d = rdata_q;
        end
        first_d    = 1'b0;
        scan_ptr_d = next_slot(scan_ptr_q);
        left_d     = left_q - CntW'(1);
        if (left_q == CntW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    left_q     <= left_d;
    first_q    <= first_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
    sum_q      <= sum_d;
    min_q      <= min_d;
    max_q      <= max_d;
    if (out_load) begin
      status_o        <= status_q;
      removed_value_o <= removed_q;
      entry_count_o   <= 4'(occ_q);
      entry_sum_o     <= sum_q;
      entry_min_o     <= min_q;
      entry_max_o     <= max_q;
      is_full_o       <= occ_full;
      is_empty_o      <= (occ_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(Depth))
    else $error("occupancy above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_q == '0) || occ_full) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree with occupancy");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_FULL)) |-> is_full_o)
    else $error("refused enqueue without full flag");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_EMPTY)) |-> (is_empty_o && removed_value_o == '0))
    else $error("refused dequeue with data");

  a_scan_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((left_q != '0) && (left_q <= occ_q)))
    else $error("scan count out of range");
`endif

endmodule

>>> tb/tb_circular_queue_with_stats.sv
`timescale 1ns / 1ps

module tb_circular_queue_with_stats;
  import cqs_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed;
    logic [3:0]         count;
    logic signed [34:0] sum;
    logic signed [31:0] min_v;
    logic signed [31:0] max_v;
    logic               full;
    logic               empty;
  } queue_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = MODE_NOP;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] removed_value_o;
  logic [3:0]         entry_count_o;
  logic signed [34:0] entry_sum_o;
  logic signed [31:0] entry_min_o;
  logic signed [31:0] entry_max_o;
  logic               is_full_o;
  logic               is_empty_o;

  // queue image kept alongside the block
  logic signed [31:0] ring [Depth];
  int                 wr_ptr = 0;
  int                 rd_ptr = 0;
  int                 fill = 0;

  queue_result_t pending_results[$];
  int            error_count = 0;
  int            send_gap_pct = 0;
  int            recv_gap_pct = 0;
  int            hold_request = 0;
  int            hold_left = 0;

  circular_queue_with_stats uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .entry_count_o  (entry_count_o),
    .entry_sum_o    (entry_sum_o),
    .entry_min_o    (entry_min_o),
    .entry_max_o    (entry_max_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic queue_result_t apply_command(input logic [1:0] mode,
                                                  input logic signed [31:0] value);
    queue_result_t      r;
    longint             acc;
    logic signed [31:0] v;
    int                 p;
    r = '0;
    case (mode)
      MODE_ENQ: begin
        if (fill >= Depth) begin
          r.status = STAT_FULL;
        end else begin
          ring[wr_ptr] = value;
          wr_ptr = (wr_ptr + 1) % Depth;
          fill++;
        end
      end
      MODE_DEQ: begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.removed = ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % Depth;
          fill--;
        end
      end
      MODE_RPT: begin
        if (fill > 0) begin
          acc = 0;
          p = rd_ptr;
          r.min_v = ring[p];
          r.max_v = ring[p];
          for (int i = 0; i < fill; i++) begin
            v = ring[p];
            acc += v;
            if (v < r.min_v) r.min_v = v;
            if (v > r.max_v) r.max_v = v;
            p = (p + 1) % Depth;
          end
          r.sum = acc[34:0];
        end
      end
      default: begin
      end
    endcase
    r.count = fill[3:0];
    r.full  = (fill >= Depth);
    r.empty = (fill == 0);
    return r;
  endfunction

  // receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    queue_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: status %0d", status_o);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          error_count++;
        end
        if (removed_value_o !== e.removed) begin
          $error("removed_value: expected %0d, got %0d", e.removed, removed_value_o);
          error_count++;
        end
        if (entry_count_o !== e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, entry_count_o);
          error_count++;
        end
        if (entry_sum_o !== e.sum) begin
          $error("entry_sum: expected %0d, got %0d", e.sum, entry_sum_o);
          error_count++;
        end
        if (entry_min_o !== e.min_v) begin
          $error("entry_min: expected %0d, got %0d", e.min_v, entry_min_o);
          error_count++;
        end
        if (entry_max_o !== e.max_v) begin
          $error("entry_max: expected %0d, got %0d", e.max_v, entry_max_o);
          error_count++;
        end
        if (is_full_o !== e.full) begin
          $error("is_full: expected %0d, got %0d", e.full, is_full_o);
          error_count++;
        end
        if (is_empty_o !== e.empty) begin
          $error("is_empty: expected %0d, got %0d", e.empty, is_empty_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic signed [31:0] value);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pending_results.push_back(apply_command(mode, value));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      2: v = '0;
      3: v = -32'sd1;
      4: v = $signed($urandom_range(0, 16)) - 32'sd8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_empty_queue();
    send_item(MODE_RPT, 32'sd5);
    send_item(MODE_DEQ, 32'sh7FFF_FFFF);
    send_item(MODE_NOP, -32'sd1);
    wait_drain();
  endtask

  // stored zero, extremes, refused enqueue on full, drain past empty
  task automatic test_fill_and_drain();
    logic signed [31:0] fill_vals [8];
    fill_vals = '{32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd1,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd12345};
    send_item(MODE_ENQ, fill_vals[0]);
    send_item(MODE_RPT, '0);
    for (int i = 1; i < Depth; i++) begin
      send_item(MODE_ENQ, fill_vals[i % 8]);
    end
    send_item(MODE_ENQ, 32'sd99);
    send_item(MODE_RPT, '0);
    send_item(MODE_NOP, '0);
    for (int i = 0; i < Depth; i++) begin
      send_item(MODE_DEQ, '0);
    end
    send_item(MODE_DEQ, '0);
    send_item(MODE_RPT, '0);
    wait_drain();
  endtask

  // target occupancy wanders so that full and empty are both visited
  task automatic test_random_traffic(input int n_items);
    int target;
    int r;
    logic [1:0] mode;
    target = $urandom_range(0, Depth + 1);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 15) == 0) target = $urandom_range(0, Depth + 1);
      r = $urandom_range(0, 99);
      if (r < 4) mode = MODE_NOP;
      else if (r < 20) mode = MODE_RPT;
      else if (fill < target || target == Depth + 1) mode = MODE_ENQ;
      else mode = MODE_DEQ;
      if ($urandom_range(0, 9) == 0) mode = 2'($urandom_range(0, 3));
      send_item(mode, pick_value());
    end
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    send_gap_pct = 0;
    hold_request = 300;
    for (int i = 0; i < 24; i++) begin
      send_item((i % 3 == 2) ? MODE_RPT : MODE_ENQ, pick_value());
    end
    wait_drain();
  endtask

  initial begin
    send_gap_pct = 29;
    recv_gap_pct = 88;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_and_drain();
    test_random_traffic(380);
    send_gap_pct = 88;
    recv_gap_pct = 29;
    test_random_traffic(380);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(380);
    test_output_backpressure();

    wait_drain();
    repeat (Depth + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cqs_pkg.sv
rtl/core/circular_queue_with_stats.sv
tb/tb_circular_queue_with_stats.sv
